### hw/rtl/ffha_pkg.sv
// Shared types and constants of the first-fit heap allocator.
package ffha_pkg;

    localparam int unsigned HEAP_BYTES_DEF   = 65536;
    localparam int unsigned HEADER_BYTES_DEF = 8;
    localparam int unsigned HEAP_RESET       = 65536;
    localparam int unsigned HEAP_MIN         = 32;
    localparam int unsigned SPLIT_SPARE      = 16;

    localparam int unsigned REQ_W   = 16;
    localparam int unsigned ADDR_W  = 16;
    localparam int unsigned BYTES_W = 17;
    localparam int unsigned CFG_W   = 17;

    typedef enum logic {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } t_action;

    typedef struct packed {
        t_action                  action;
        logic [REQ_W-1:0]         request_bytes;
        logic [ADDR_W-1:0]        block_addr;
    } t_req;

    typedef struct packed {
        logic                     ok;
        logic [ADDR_W-1:0]        result_addr;
        logic [BYTES_W-1:0]       result_bytes;
    } t_rsp;

endpackage

### hw/rtl/ffha_req_if.sv
// Request and response channel interfaces of the heap allocator.
interface ffha_req_if
    import ffha_pkg::*;
;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ffha_rsp_if
    import ffha_pkg::*;
;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/ffha_ram.sv
// Generic single-port RAM with registered read.
module ffha_ram #(
    parameter int unsigned WIDTH = 34,
    parameter int unsigned DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;
endmodule

### hw/rtl/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator with coalescing free list.
// Each request walks the address-ordered free list held in one single-port
// header RAM: each free block visited is read, then compared, since every
// header read is registered. An allocate then splits and relinks the block,
// a free merges and relinks, and the S_DONE state hands the response to the
// output register, which lets the next request be accepted while a response
// waits. After reset and after each write of heap_size the block writes the
// single free header.
module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int unsigned HEAP_BYTES   = HEAP_BYTES_DEF,
    parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_data,
    ffha_req_if.sink          i_req,
    ffha_rsp_if.source        o_rsp
);
    localparam int unsigned DEPTH = HEAP_BYTES / 4;
    localparam int unsigned IW    = $clog2(DEPTH);
    localparam int unsigned AW    = IW + 2;
    localparam int unsigned SW    = AW + 1;
    localparam int unsigned XW    = (AW + 2 > 19) ? AW + 2 : 19;
    localparam int unsigned HDR   = ((HEADER_BYTES + 3) / 4) * 4;
    localparam int unsigned MW    = AW + 1 + SW;

    typedef enum logic [20:0] {
        S_INIT   = 21'b000000000000000000001,
        S_IDLE   = 21'b000000000000000000010,
        S_DONE   = 21'b000000000000000000100,
        S_AWALK  = 21'b000000000000000001000,
        S_ACHK   = 21'b000000000000000010000,
        S_ASPLIT = 21'b000000000000000100000,
        S_ACUR   = 21'b000000000000001000000,
        S_APRD   = 21'b000000000000010000000,
        S_APWR   = 21'b000000000000100000000,
        S_FWALK  = 21'b000000000001000000000,
        S_FNEXT  = 21'b000000000010000000000,
        S_FRDC   = 21'b000000000100000000000,
        S_FRDP   = 21'b000000001000000000000,
        S_FDEC   = 21'b000000010000000000000,
        S_FAMRG  = 21'b000000100000000000000,
        S_FWRP   = 21'b000001000000000000000,
        S_FBMRG  = 21'b000010000000000000000,
        S_FBPRD  = 21'b000100000000000000000,
        S_FBPWR  = 21'b001000000000000000000,
        S_FCRD   = 21'b010000000000000000000,
        S_FCWR   = 21'b100000000000000000000
    } t_state;

    function automatic logic [SW-1:0] clamp_heap(input logic [XW-1:0] v);
        logic [XW-1:0] t;
        t = v;
        if (t < XW'(HEAP_MIN)) t = XW'(HEAP_MIN);
        if (t > XW'(HEAP_BYTES)) t = XW'(HEAP_BYTES);
        return SW'(t & ~XW'(3));
    endfunction

    t_state          r_state, n_state;
    logic [SW-1:0]   r_heap, n_heap;
    logic [AW-1:0]   r_head, n_head;
    logic            r_head_ok, n_head_ok;
    logic [AW-1:0]   r_cur, n_cur;
    logic            r_cur_ok, n_cur_ok;
    logic [AW-1:0]   r_prev, n_prev;
    logic            r_have_prev, n_have_prev;
    logic [IW:0]     r_cnt, n_cnt;
    logic [XW-1:0]   r_need, n_need;
    logic [AW-1:0]   r_c, n_c;
    logic [SW-1:0]   r_hsize, n_hsize;
    logic [SW-1:0]   r_psize, n_psize;
    logic [AW-1:0]   r_link, n_link;
    logic            r_link_ok, n_link_ok;
    logic            r_oob;
    logic            r_res_ok, n_res_ok;
    logic [AW-1:0]   r_res_addr, n_res_addr;
    logic [SW-1:0]   r_res_bytes, n_res_bytes;
    logic            r_ovalid, n_ovalid;
    t_rsp            r_out, n_out;

    logic            mem_en, mem_we;
    logic [AW-1:0]   mem_addr;
    logic [AW-1:0]   mem_wlink;
    logic            mem_wlok;
    logic [SW-1:0]   mem_wsize;
    logic [IW-1:0]   mem_idx;
    logic            mem_in;
    logic [MW-1:0]   mem_q;

    logic [AW-1:0]   rd_link;
    logic            rd_lok;
    logic [SW-1:0]   rd_size;
    logic [XW-1:0]   need_c;
    logic [ADDR_W-1:0] c_in;
    logic [XW-1:0]   psz;

    assign mem_idx = mem_addr[AW-1:2];
    assign mem_in  = ({1'b0, mem_idx} < (IW+1)'(DEPTH));

    ffha_ram #(.WIDTH(MW), .DEPTH(DEPTH)) u_hdr_ram (
        .i_clk   (i_clk),
        .i_en    (mem_en & mem_in),
        .i_we    (mem_we),
        .i_addr  (mem_idx),
        .i_wdata ({mem_wlink, mem_wlok, mem_wsize}),
        .o_rdata (mem_q)
    );

    assign rd_link = r_oob ? '0 : mem_q[MW-1 -: AW];
    assign rd_lok  = r_oob ? 1'b0 : mem_q[SW];
    assign rd_size = r_oob ? '0 : mem_q[SW-1:0];

    assign need_c = ((XW'(i_req.data.request_bytes) + XW'(3)) & ~XW'(3)) + XW'(HDR);
    assign c_in   = i_req.data.block_addr & ~ADDR_W'(3);
    assign psz    = XW'(rd_size) + XW'(r_hsize);

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_heap      = r_heap;
        n_head      = r_head;
        n_head_ok   = r_head_ok;
        n_cur       = r_cur;
        n_cur_ok    = r_cur_ok;
        n_prev      = r_prev;
        n_have_prev = r_have_prev;
        n_cnt       = r_cnt;
        n_need      = r_need;
        n_c         = r_c;
        n_hsize     = r_hsize;
        n_psize     = r_psize;
        n_link      = r_link;
        n_link_ok   = r_link_ok;
        n_res_ok    = r_res_ok;
        n_res_addr  = r_res_addr;
        n_res_bytes = r_res_bytes;
        n_ovalid    = r_ovalid & ~o_rsp.ready;
        n_out       = r_out;
        mem_en      = 1'b0;
        mem_we      = 1'b0;
        mem_addr    = '0;
        mem_wlink   = '0;
        mem_wlok    = 1'b0;
        mem_wsize   = '0;

        case (r_state)
            S_INIT: begin
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                mem_wsize = r_heap;
                n_state   = S_IDLE;
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_cur       = r_head;
                    n_cur_ok    = r_head_ok;
                    n_have_prev = 1'b0;
                    n_prev      = '0;
                    n_cnt       = '0;
                    n_res_addr  = '0;
                    n_res_bytes = '0;
                    if (i_req.data.action == ACT_ALLOC) begin
                        n_res_ok = 1'b0;
                        n_need   = need_c;
                        n_state  = (i_req.data.request_bytes == '0) ? S_DONE : S_AWALK;
                    end else begin
                        n_c = AW'(c_in);
                        if (XW'(c_in) >= XW'(r_heap)) begin
                            n_res_ok = 1'b0;
                            n_state  = S_DONE;
                        end else begin
                            n_res_ok = 1'b1;
                            n_state  = S_FWALK;
                        end
                    end
                end
            end
            S_DONE: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid           = 1'b1;
                    n_out.ok           = r_res_ok;
                    n_out.result_addr  = ADDR_W'(r_res_addr);
                    n_out.result_bytes = BYTES_W'(r_res_bytes);
                    n_state            = S_IDLE;
                end
            end
            S_AWALK: begin
                if (!r_cur_ok || r_cnt >= (IW+1)'(DEPTH)) begin
                    n_state = S_DONE;
                end else begin
                    mem_en   = 1'b1;
                    mem_addr = r_cur;
                    n_cnt    = r_cnt + 1'b1;
                    n_state  = S_ACHK;
                end
            end
            S_ACHK: begin
                if (XW'(rd_size) >= r_need) begin
                    n_hsize   = rd_size;
                    n_link    = rd_link;
                    n_link_ok = rd_lok;
                    n_state   = S_ASPLIT;
                end else begin
                    n_prev      = r_cur;
                    n_have_prev = 1'b1;
                    n_cur       = rd_link;
                    n_cur_ok    = rd_lok;
                    n_state     = S_AWALK;
                end
            end
            S_ASPLIT: begin
                if (XW'(r_hsize) >= r_need + XW'(HDR) + XW'(SPLIT_SPARE)) begin
                    mem_en    = 1'b1;
                    mem_we    = 1'b1;
                    mem_addr  = r_cur + AW'(r_need);
                    mem_wlink = r_link;
                    mem_wlok  = r_link_ok;
                    mem_wsize = r_hsize - SW'(r_need);
                    n_link    = r_cur + AW'(r_need);
                    n_link_ok = 1'b1;
                    n_hsize   = SW'(r_need);
                end
                n_state = S_ACUR;
            end
            S_ACUR: begin
                mem_en      = 1'b1;
                mem_we      = 1'b1;
                mem_addr    = r_cur;
                mem_wsize   = r_hsize;
                n_res_ok    = 1'b1;
                n_res_addr  = r_cur;
                n_res_bytes = r_hsize;
                if (r_have_prev) begin
                    n_state = S_APRD;
                end else begin
                    n_head    = r_link;
                    n_head_ok = r_link_ok;
                    n_state   = S_DONE;
                end
            end
            S_APRD: begin
                mem_en   = 1'b1;
                mem_addr = r_prev;
                n_state  = S_APWR;
            end
            S_APWR: begin
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                mem_addr  = r_prev;
                mem_wlink = r_link;
                mem_wlok  = r_link_ok;
                mem_wsize = rd_size;
                n_state   = S_DONE;
            end
            S_FWALK: begin
                if (!r_cur_ok || ((!r_have_prev || r_c >= r_prev) && r_c <= r_cur)) begin
                    n_state = S_FRDC;
                end else if (r_cnt >= (IW+1)'(DEPTH)) begin
                    n_res_ok = 1'b0;
                    n_state  = S_DONE;
                end else begin
                    n_prev      = r_cur;
                    n_have_prev = 1'b1;
                    n_cnt       = r_cnt + 1'b1;
                    mem_en      = 1'b1;
                    mem_addr    = r_cur;
                    n_state     = S_FNEXT;
                end
            end
            S_FNEXT: begin
                n_cur    = rd_link;
                n_cur_ok = rd_lok;
                n_state  = S_FWALK;
            end
            S_FRDC: begin
                mem_en   = 1'b1;
                mem_addr = r_c;
                n_state  = S_FRDP;
            end
            S_FRDP: begin
                n_hsize  = rd_size;
                mem_en   = 1'b1;
                mem_addr = r_prev;
                n_state  = S_FDEC;
            end
            S_FDEC: begin
                if (r_have_prev && XW'(r_prev) + XW'(rd_size) == XW'(r_c)) begin
                    n_psize   = SW'(psz);
                    n_link    = rd_link;
                    n_link_ok = rd_lok;
                    if (r_cur_ok && XW'(r_prev) + psz == XW'(r_cur)) begin
                        mem_en   = 1'b1;
                        mem_addr = r_cur;
                        n_state  = S_FAMRG;
                    end else begin
                        n_state = S_FWRP;
                    end
                end else if (r_cur_ok && XW'(r_c) + XW'(r_hsize) == XW'(r_cur)) begin
                    mem_en   = 1'b1;
                    mem_addr = r_cur;
                    n_state  = S_FBMRG;
                end else if (r_have_prev) begin
                    mem_en    = 1'b1;
                    mem_we    = 1'b1;
                    mem_addr  = r_prev;
                    mem_wlink = r_c;
                    mem_wlok  = 1'b1;
                    mem_wsize = rd_size;
                    n_state   = S_FCRD;
                end else begin
                    n_head    = r_c;
                    n_head_ok = 1'b1;
                    mem_en    = 1'b1;
                    mem_we    = 1'b1;
                    mem_addr  = r_c;
                    mem_wlink = r_cur;
                    mem_wlok  = r_cur_ok;
                    mem_wsize = r_hsize;
                    n_state   = S_DONE;
                end
            end
            S_FAMRG: begin
                n_psize   = r_psize + rd_size;
                n_link    = rd_link;
                n_link_ok = rd_lok;
                n_state   = S_FWRP;
            end
            S_FWRP: begin
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                mem_addr  = r_prev;
                mem_wlink = r_link;
                mem_wlok  = r_link_ok;
                mem_wsize = r_psize;
                n_state   = S_DONE;
            end
            S_FBMRG: begin
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                mem_addr  = r_c;
                mem_wlink = rd_link;
                mem_wlok  = rd_lok;
                mem_wsize = r_hsize + rd_size;
                if (r_have_prev) begin
                    n_state = S_FBPRD;
                end else begin
                    n_head    = r_c;
                    n_head_ok = 1'b1;
                    n_state   = S_DONE;
                end
            end
            S_FBPRD: begin
                mem_en   = 1'b1;
                mem_addr = r_prev;
                n_state  = S_FBPWR;
            end
            S_FBPWR: begin
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                mem_addr  = r_prev;
                mem_wlink = r_c;
                mem_wlok  = 1'b1;
                mem_wsize = rd_size;
                n_state   = S_DONE;
            end
            S_FCRD: begin
                mem_en   = 1'b1;
                mem_addr = r_c;
                n_state  = S_FCWR;
            end
            S_FCWR: begin
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                mem_addr  = r_c;
                mem_wlink = r_cur;
                mem_wlok  = r_cur_ok;
                mem_wsize = rd_size;
                n_state   = S_DONE;
            end
            default: begin
                n_state = S_INIT;
            end
        endcase

        if (i_cfg_we) begin
            n_heap    = clamp_heap(XW'(i_cfg_data));
            n_head    = '0;
            n_head_ok = 1'b1;
            n_state   = S_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_heap    <= clamp_heap(XW'(HEAP_RESET));
            r_head    <= '0;
            r_head_ok <= 1'b1;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_heap    <= n_heap;
            r_head    <= n_head;
            r_head_ok <= n_head_ok;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur       <= n_cur;
        r_cur_ok    <= n_cur_ok;
        r_prev      <= n_prev;
        r_have_prev <= n_have_prev;
        r_cnt       <= n_cnt;
        r_need      <= n_need;
        r_c         <= n_c;
        r_hsize     <= n_hsize;
        r_psize     <= n_psize;
        r_link      <= n_link;
        r_link_ok   <= n_link_ok;
        r_res_ok    <= n_res_ok;
        r_res_addr  <= n_res_addr;
        r_res_bytes <= n_res_bytes;
        r_out       <= n_out;
        if (mem_en && !mem_we) begin
            r_oob <= ~mem_in;
        end
    end
endmodule

### hw/rtl/ffha_chk.sv
// Port-level assertion checker of the heap allocator and its bind.
module ffha_chk
    import ffha_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_req_ready,
    input logic               o_rsp_valid,
    input logic               o_rsp_ready,
    input logic               o_rsp_ok,
    input logic [ADDR_W-1:0]  o_rsp_addr,
    input logic [BYTES_W-1:0] o_rsp_bytes
);
    a_reset_blocks: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_req_ready && !o_rsp_valid)
        else $error("request taken or response shown right after reset");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !o_rsp_ready |=> o_rsp_valid)
        else $error("response dropped while stalled");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !o_rsp_ok |-> o_rsp_addr == '0 && o_rsp_bytes == '0)
        else $error("failed request reports a block");

    a_word_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> o_rsp_addr[1:0] == 2'b00 && o_rsp_bytes[1:0] == 2'b00)
        else $error("block offset or size not word aligned");
endmodule

bind first_fit_heap_allocator ffha_chk u_ffha_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_ready (i_req.ready),
    .o_rsp_valid (o_rsp.valid),
    .o_rsp_ready (o_rsp.ready),
    .o_rsp_ok    (o_rsp.data.ok),
    .o_rsp_addr  (o_rsp.data.result_addr),
    .o_rsp_bytes (o_rsp.data.result_bytes)
);

### tb/first_fit_heap_allocator_tb.sv
// Testbench of the first-fit heap allocator: directed and random requests checked against a free-list model.
`timescale 1ns / 1ps

module first_fit_heap_allocator_tb;
    import ffha_pkg::*;

    localparam int unsigned HDR    = (HEADER_BYTES_DEF + 3) & ~3;
    localparam int unsigned DEPTH  = HEAP_BYTES_DEF / 4;
    localparam string       PASS_MSG = "** first_fit_heap_allocator: PASSED **";

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_data;

    ffha_req_if req_ch ();
    ffha_rsp_if rsp_ch ();

    first_fit_heap_allocator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    int unsigned  hdr_link [DEPTH];
    logic         hdr_link_ok [DEPTH];
    int unsigned  hdr_len [DEPTH];
    int unsigned  list_head;
    logic         list_head_ok;
    int unsigned  heap_bytes;

    t_rsp         expected_rsp [$];
    int unsigned  live_blocks [$];
    int           mismatches = 0;
    int           stall_hold = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("** first_fit_heap_allocator: FAILED **");
        $finish;
    end

    function automatic void heap_reinit(int unsigned v);
        if (v < HEAP_MIN) v = HEAP_MIN;
        if (v > HEAP_BYTES_DEF) v = HEAP_BYTES_DEF;
        heap_bytes = v & ~32'd3;
        list_head = 0;
        list_head_ok = 1'b1;
        hdr_link[0] = 0;
        hdr_link_ok[0] = 1'b0;
        hdr_len[0] = heap_bytes;
    endfunction

    function automatic void hdr_write(int unsigned a, int unsigned lk, logic lk_ok,
                                      int unsigned sz);
        if ((a >> 2) < DEPTH) begin
            hdr_link[a >> 2] = lk;
            hdr_link_ok[a >> 2] = lk_ok;
            hdr_len[a >> 2] = sz;
        end
    endfunction

    function automatic t_rsp predict_alloc(int unsigned req);
        t_rsp r;
        int unsigned need, cur, prev, nxt, sz, n;
        logic cur_ok, have_prev, nxt_ok;
        r = '0;
        prev = 0;
        have_prev = 1'b0;
        n = 0;
        if (req == 0) return r;
        need = ((req + 3) & ~32'd3) + HDR;
        cur = list_head;
        cur_ok = list_head_ok;
        while (cur_ok) begin
            if (n++ >= DEPTH) return r;
            if (hdr_len[cur >> 2] >= need) break;
            prev = cur;
            have_prev = 1'b1;
            cur_ok = hdr_link_ok[cur >> 2];
            cur = hdr_link[cur >> 2];
        end
        if (!cur_ok) return r;
        sz = hdr_len[cur >> 2];
        nxt = hdr_link[cur >> 2];
        nxt_ok = hdr_link_ok[cur >> 2];
        if (sz >= need + HDR + SPLIT_SPARE) begin
            hdr_write(cur + need, nxt, nxt_ok, sz - need);
            nxt = cur + need;
            nxt_ok = 1'b1;
            sz = need;
        end
        hdr_write(cur, 0, 1'b0, sz);
        if (have_prev) begin
            hdr_link[prev >> 2] = nxt;
            hdr_link_ok[prev >> 2] = nxt_ok;
        end else begin
            list_head = nxt;
            list_head_ok = nxt_ok;
        end
        r.ok = 1'b1;
        r.result_addr = 16'(cur);
        r.result_bytes = 17'(sz);
        return r;
    endfunction

    function automatic t_rsp predict_free(int unsigned c);
        t_rsp r;
        int unsigned prev, nx, n, csz, psz;
        logic have_prev, nx_ok;
        r = '0;
        prev = 0;
        have_prev = 1'b0;
        n = 0;
        c = c & ~32'd3;
        if (c >= heap_bytes) return r;
        nx = list_head;
        nx_ok = list_head_ok;
        while (nx_ok) begin
            if ((!have_prev || c >= prev) && c <= nx) break;
            if (n++ >= DEPTH) return r;
            prev = nx;
            have_prev = 1'b1;
            nx_ok = hdr_link_ok[nx >> 2];
            nx = hdr_link[nx >> 2];
        end
        csz = hdr_len[c >> 2];
        psz = hdr_len[prev >> 2];
        if (have_prev && prev + psz == c) begin
            psz += csz;
            if (nx_ok && prev + psz == nx) begin
                psz += hdr_len[nx >> 2];
                hdr_write(prev, hdr_link[nx >> 2], hdr_link_ok[nx >> 2], psz);
            end else begin
                hdr_len[prev >> 2] = psz;
            end
        end else if (nx_ok && c + csz == nx) begin
            hdr_write(c, hdr_link[nx >> 2], hdr_link_ok[nx >> 2], csz + hdr_len[nx >> 2]);
            if (have_prev) begin
                hdr_link[prev >> 2] = c;
                hdr_link_ok[prev >> 2] = 1'b1;
            end else begin
                list_head = c;
                list_head_ok = 1'b1;
            end
        end else begin
            if (have_prev) begin
                hdr_link[prev >> 2] = c;
                hdr_link_ok[prev >> 2] = 1'b1;
            end else begin
                list_head = c;
                list_head_ok = 1'b1;
            end
            hdr_link[c >> 2] = nx;
            hdr_link_ok[c >> 2] = nx_ok;
        end
        r.ok = 1'b1;
        return r;
    endfunction

    task automatic send_req(t_action act, logic [15:0] rb, logic [15:0] ba);
        int gap;
        int unsigned pick;
        t_rsp r;
        pick = $urandom_range(99);
        gap = (pick < 65) ? 0 : (pick < 95) ? $urandom_range(3, 1) : $urandom_range(40, 10);
        @(negedge i_clk);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data.action <= act;
        req_ch.data.request_bytes <= rb;
        req_ch.data.block_addr <= ba;
        do @(posedge i_clk); while (!req_ch.ready);
        if (act == ACT_ALLOC) begin
            r = predict_alloc(32'(rb));
            if (r.ok) live_blocks.push_back(32'(r.result_addr));
        end else begin
            r = predict_free(32'(ba));
        end
        expected_rsp.push_back(r);
    endtask

    task automatic free_live(int idx);
        int unsigned a;
        a = live_blocks[idx];
        live_blocks.delete(idx);
        send_req(ACT_FREE, 16'($urandom), 16'(a | $urandom_range(3)));
    endtask

    task automatic wait_idle();
        int n;
        n = 0;
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (expected_rsp.size() != 0 && n < 200000) begin
            @(negedge i_clk);
            n++;
        end
        repeat (20) @(negedge i_clk);
    endtask

    task automatic set_heap(logic [CFG_W-1:0] v);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        heap_reinit(32'(v));
        live_blocks.delete();
        repeat (3) @(negedge i_clk);
    endtask

    task automatic random_mix(int count, int unsigned max_req);
        int unsigned pick, rb;
        repeat (count) begin
            pick = $urandom_range(99);
            if (live_blocks.size() == 0 || pick < 50 + (live_blocks.size() < 40 ? 5 : -15)) begin
                pick = $urandom_range(99);
                rb = (pick < 3) ? 0 : (pick < 8) ? $urandom_range(65535)
                   : (pick < 80) ? $urandom_range(64, 1) : $urandom_range(max_req, 1);
                send_req(ACT_ALLOC, 16'(rb), 16'($urandom));
            end else if (pick < 98 || heap_bytes > 65535) begin
                free_live($urandom_range(live_blocks.size() - 1));
            end else begin
                send_req(ACT_FREE, 16'($urandom), 16'($urandom_range(65535, heap_bytes)));
            end
        end
    endtask

    task automatic test_edges();
        send_req(ACT_ALLOC, 16'd0, 16'hffff);
        send_req(ACT_ALLOC, 16'hffff, 16'd0);
        send_req(ACT_ALLOC, 16'(HEAP_BYTES_DEF - HDR), 16'd0);
        send_req(ACT_ALLOC, 16'd1, 16'd0);
        free_live(0);
        set_heap(17'd1001);
        send_req(ACT_ALLOC, 16'd968, 16'd0);
        send_req(ACT_ALLOC, 16'd16, 16'd0);
        send_req(ACT_FREE, 16'd0, 16'd1000);
        send_req(ACT_FREE, 16'd0, 16'hfffc);
        free_live(1);
        free_live(0);
        send_req(ACT_ALLOC, 16'd972, 16'd0);
        free_live(0);
        send_req(ACT_ALLOC, 16'd4, 16'd0);
        send_req(ACT_ALLOC, 16'd8, 16'd0);
        send_req(ACT_ALLOC, 16'd12, 16'd0);
        free_live(1);
        free_live(0);
        free_live(0);
    endtask

    task automatic test_random_sizes();
        set_heap(17'd31);
        random_mix(60, 16);
        set_heap(17'h1ffff);
        random_mix(300, 8000);
        set_heap(17'd4095);
        random_mix(200, 300);
        set_heap(17'd65536);
        random_mix(250, 2000);
    endtask

    task automatic test_backpressure();
        @(negedge i_clk);
        stall_hold = 400;
        random_mix(30, 64);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        for (int i = 0; i < DEPTH; i++) hdr_write(i * 4, 0, 1'b0, 0);
        heap_reinit(HEAP_RESET);
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (3) @(negedge i_clk);
        test_edges();
        test_random_sizes();
        test_backpressure();
        wait_idle();
        repeat (50) @(negedge i_clk);
        if (mismatches == 0 && expected_rsp.size() == 0) begin
            $display(PASS_MSG);
        end else begin
            $display("** first_fit_heap_allocator: FAILED **");
        end
        $finish;
    end

    initial begin
        int unsigned pick;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_hold > 0) begin
                rsp_ch.ready <= 1'b0;
                stall_hold--;
            end else begin
                pick = $urandom_range(99);
                if (pick < 75) begin
                    rsp_ch.ready <= 1'b1;
                end else begin
                    rsp_ch.ready <= 1'b0;
                    if (pick > 96) stall_hold = $urandom_range(30, 8);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected response %p", rsp_ch.data);
            end else begin
                want = expected_rsp.pop_front();
                if (rsp_ch.data.ok !== want.ok || rsp_ch.data.result_addr !== want.result_addr
                        || rsp_ch.data.result_bytes !== want.result_bytes) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display({"response mismatch: expected ok=%0d addr=%0d bytes=%0d,",
                                  " got ok=%0d addr=%0d bytes=%0d"},
                                 want.ok, want.result_addr, want.result_bytes, rsp_ch.data.ok,
                                 rsp_ch.data.result_addr, rsp_ch.data.result_bytes);
                    end
                end
            end
        end
    end

endmodule
